[sv/swing_ar_pkg.sv]
package swing_ar_pkg;

    localparam int RANK_W = 20;
    localparam int SIZE_W = 21;
    localparam int STEP_W = 5;
    localparam int ACT_W  = 3;
    localparam int LOG_W  = 5;

    // Largest group size the schedule supports
    localparam logic [SIZE_W-1:0] RANK_LIMIT = 21'h100000;

    typedef enum logic [ACT_W-1:0] {
        ACT_SEND_OWN    = 3'd0,
        ACT_RECV_REDUCE = 3'd1,
        ACT_EXCHANGE    = 3'd2,
        ACT_SEND_RESULT = 3'd3,
        ACT_RECV_RESULT = 3'd4,
        ACT_NONE        = 3'd5,
        ACT_ERROR       = 3'd6
    } action_t;

    // Role of the member within the folded group
    typedef enum logic [2:0] {
        CLS_ERROR,
        CLS_SINGLE,
        CLS_LOW_EVEN,
        CLS_LOW_ODD,
        CLS_PLAIN
    } member_cls_t;

    typedef struct packed {
        logic    load_req;
        logic    setup_lg;
        logic    setup_cls;
        logic    step_adv;
        logic    out_load;
        action_t out_act;
        logic    out_last;
    } dp_cmd_t;

    typedef struct packed {
        member_cls_t cls;
        logic        step_last;
        logic        out_free;
    } dp_status_t;

    // Index of the highest set bit, zero for an all-zero word
    function automatic logic [LOG_W-1:0] msb_index(input logic [SIZE_W-1:0] v);
        logic [LOG_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < SIZE_W; i++)
        begin
            if (v[i])
            begin
                idx = LOG_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[sv/swing_ar_datapath.sv]
module swing_ar_datapath #(
    parameter int MAX_STEPS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [swing_ar_pkg::RANK_W-1:0]     member_rank,
    input  logic [swing_ar_pkg::SIZE_W-1:0]     group_size,
    input  swing_ar_pkg::dp_cmd_t               cmd,
    output swing_ar_pkg::dp_status_t            status,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [swing_ar_pkg::ACT_W-1:0]      action,
    output logic [swing_ar_pkg::RANK_W-1:0]     peer,
    output logic [swing_ar_pkg::STEP_W-1:0]     step_index,
    output logic                                last_of_run
);

    localparam int RW = swing_ar_pkg::RANK_W;
    localparam int SW = swing_ar_pkg::SIZE_W;
    localparam int TW = swing_ar_pkg::STEP_W;
    localparam int LW = swing_ar_pkg::LOG_W;

    // Request and setup registers
    logic [RW-1:0]               rank_reg;
    logic [SW-1:0]               size_reg;
    logic [LW-1:0]               lg_reg;
    logic [RW-1:0]               extra_reg;
    logic                        err_reg;
    logic [RW-1:0]               mask_reg;
    logic [RW-1:0]               vr_reg;
    swing_ar_pkg::member_cls_t   cls_reg;
    logic [TW-1:0]               step_reg;
    logic [RW-1:0]               rho_reg;

    // Output word
    logic                        valid_reg;
    swing_ar_pkg::action_t       act_reg;
    logic [RW-1:0]               peer_reg;
    logic [TW-1:0]               step_out_reg;
    logic                        last_reg;

    logic [LW-1:0]               lg_next;
    logic [SW-1:0]               adj_next;
    logic [RW-1:0]               extra_next;
    logic                        err_next;
    logic                        low_w;
    logic [RW-1:0]               w_val;
    logic [RW-1:0]               dest;
    logic [RW-1:0]               peer_next;

    // Fold the group: highest power of two and the extra members above it
    always_comb
    begin
        lg_next    = swing_ar_pkg::msb_index(size_reg);
        adj_next   = SW'(1) << lg_next;
        extra_next = RW'(size_reg - adj_next);
        err_next   = (size_reg == '0) || (size_reg > swing_ar_pkg::RANK_LIMIT)
                     || ({1'b0, rank_reg} >= size_reg);
    end

    assign low_w = {1'b0, rank_reg} < {extra_reg, 1'b0};

    // Exchange partner for the current step, mapped back to a real rank
    always_comb
    begin
        if (vr_reg[0])
        begin
            w_val = (vr_reg - rho_reg) & mask_reg;
        end
        else
        begin
            w_val = (vr_reg + rho_reg) & mask_reg;
        end
        if (w_val < extra_reg)
        begin
            dest = {w_val[RW-2:0], 1'b1};
        end
        else
        begin
            dest = w_val + extra_reg;
        end
    end

    // Pick the partner for the action being issued
    always_comb
    begin
        case (cmd.out_act)
            swing_ar_pkg::ACT_SEND_OWN,
            swing_ar_pkg::ACT_RECV_RESULT: peer_next = rank_reg + RW'(1);
            swing_ar_pkg::ACT_RECV_REDUCE,
            swing_ar_pkg::ACT_SEND_RESULT: peer_next = rank_reg - RW'(1);
            swing_ar_pkg::ACT_EXCHANGE:    peer_next = dest;
            default:                       peer_next = '0;
        endcase
    end

    // Hold the request and advance the exchange sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg  <= '0;
            size_reg  <= '0;
            lg_reg    <= '0;
            extra_reg <= '0;
            err_reg   <= 1'b0;
            mask_reg  <= '0;
            vr_reg    <= '0;
            cls_reg   <= swing_ar_pkg::CLS_ERROR;
            step_reg  <= '0;
            rho_reg   <= RW'(1);
        end
        else
        begin
            if (cmd.load_req)
            begin
                rank_reg <= member_rank;
                size_reg <= group_size;
            end
            if (cmd.setup_lg)
            begin
                lg_reg    <= lg_next;
                extra_reg <= extra_next;
                err_reg   <= err_next;
            end
            if (cmd.setup_cls)
            begin
                mask_reg <= RW'((SW'(1) << lg_reg) - SW'(1));
                step_reg <= '0;
                rho_reg  <= RW'(1);
                if (low_w)
                begin
                    vr_reg <= rank_reg >> 1;
                end
                else
                begin
                    vr_reg <= rank_reg - extra_reg;
                end
                if (err_reg || (lg_reg > LW'(MAX_STEPS)))
                begin
                    cls_reg <= swing_ar_pkg::CLS_ERROR;
                end
                else if (size_reg == SW'(1))
                begin
                    cls_reg <= swing_ar_pkg::CLS_SINGLE;
                end
                else if (low_w && !rank_reg[0])
                begin
                    cls_reg <= swing_ar_pkg::CLS_LOW_EVEN;
                end
                else if (low_w)
                begin
                    cls_reg <= swing_ar_pkg::CLS_LOW_ODD;
                end
                else
                begin
                    cls_reg <= swing_ar_pkg::CLS_PLAIN;
                end
            end
            else if (cmd.step_adv)
            begin
                step_reg <= step_reg + TW'(1);
                rho_reg  <= RW'(1) - {rho_reg[RW-2:0], 1'b0};
            end
        end
    end

    // Output word register: load when the slot is free, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            act_reg      <= cmd.out_act;
            peer_reg     <= peer_next;
            step_out_reg <= (cmd.out_act == swing_ar_pkg::ACT_EXCHANGE) ? step_reg : '0;
            last_reg     <= cmd.out_last;
        end
    end

    assign status.cls       = cls_reg;
    assign status.step_last = (step_reg == TW'(lg_reg - LW'(1)));
    assign status.out_free  = !valid_reg || !out_stall;

    assign out_valid   = valid_reg;
    assign action      = act_reg;
    assign peer        = peer_reg;
    assign step_index  = step_out_reg;
    assign last_of_run = last_reg;

    // Never overwrite a word that is still waiting
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output word overwritten while stalled");

    // Error and idle words carry no partner or step number and are marked last
    a_err_no_peer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action == swing_ar_pkg::ACT_ERROR
                       || action == swing_ar_pkg::ACT_NONE))
        |-> (peer == '0 && step_index == '0 && last_of_run))
        else $error("error or idle word with partner or not last");

    // Step number only on exchanges
    a_step_only_exch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && action != swing_ar_pkg::ACT_EXCHANGE) |-> (step_index == '0))
        else $error("step number on a non-exchange word");

endmodule

[sv/swing_ar_ctrl.sv]
module swing_ar_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  swing_ar_pkg::dp_status_t   status,
    output swing_ar_pkg::dp_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_CLASSIFY,
        ST_HEAD,
        ST_EXCH,
        ST_TAIL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;

    // Sequence the schedule: fold, classify, then one word per free slot
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.out_act = swing_ar_pkg::ACT_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.setup_lg = 1'b1;
                state_next   = ST_CLASSIFY;
            end
            ST_CLASSIFY:
            begin
                cmd.setup_cls = 1'b1;
                state_next    = ST_HEAD;
            end
            ST_HEAD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    case (status.cls)
                        swing_ar_pkg::CLS_ERROR:
                        begin
                            cmd.out_act  = swing_ar_pkg::ACT_ERROR;
                            cmd.out_last = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        swing_ar_pkg::CLS_SINGLE:
                        begin
                            cmd.out_act  = swing_ar_pkg::ACT_NONE;
                            cmd.out_last = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        swing_ar_pkg::CLS_LOW_EVEN:
                        begin
                            cmd.out_act = swing_ar_pkg::ACT_SEND_OWN;
                            state_next  = ST_TAIL;
                        end
                        swing_ar_pkg::CLS_LOW_ODD:
                        begin
                            cmd.out_act = swing_ar_pkg::ACT_RECV_REDUCE;
                            state_next  = ST_EXCH;
                        end
                        default:
                        begin
                            cmd.out_act  = swing_ar_pkg::ACT_EXCHANGE;
                            cmd.out_last = status.step_last;
                            cmd.step_adv = 1'b1;
                            state_next   = status.step_last ? ST_IDLE : ST_EXCH;
                        end
                    endcase
                end
            end
            ST_EXCH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_act  = swing_ar_pkg::ACT_EXCHANGE;
                    cmd.step_adv = 1'b1;
                    cmd.out_last = status.step_last
                                   && (status.cls != swing_ar_pkg::CLS_LOW_ODD);
                    if (status.step_last)
                    begin
                        state_next = (status.cls == swing_ar_pkg::CLS_LOW_ODD)
                                     ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_TAIL:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.out_act  = (status.cls == swing_ar_pkg::CLS_LOW_EVEN)
                                   ? swing_ar_pkg::ACT_RECV_RESULT
                                   : swing_ar_pkg::ACT_SEND_RESULT;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        stall_next = (state_next != ST_IDLE);
    end

    // Hold state and the registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign in_stall = stall_reg;

    // Exchange steps only for members that take part in the folded group
    a_exch_cls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXCH) |->
        (status.cls == swing_ar_pkg::CLS_LOW_ODD || status.cls == swing_ar_pkg::CLS_PLAIN))
        else $error("exchange phase for a member without exchanges");

    // A word marked last always returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_last) |=> (state_reg == ST_IDLE))
        else $error("last word issued but sequencer not idle");

    // Stall follows the state: free exactly when idle
    a_stall_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (state_reg != ST_IDLE))
        else $error("stall out of step with sequencer state");

endmodule

[sv/swing_allreduce_peer_schedule.sv]
// Channel  Dir  Handshake            Words
// in       in   in_valid / in_stall   member_rank, group_size
// out      out  out_valid / out_stall action, peer, step_index, last_of_run
//
// A request is accepted, folded, then classified, then yields n result words,
// one per cycle while the output is free, n from 1 to log2(folded size) + 2.
// The exchange sequencer sets the rate: one partner per unstalled cycle.
// Reset is asynchronous, active low; the block comes up idle and accepting.
// A stall on the output freezes the sequencer; the next request is taken
// while the final word of the previous one still waits.
module swing_allreduce_peer_schedule #(
    parameter int MAX_STEPS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [swing_ar_pkg::RANK_W-1:0]     member_rank,
    input  logic [swing_ar_pkg::SIZE_W-1:0]     group_size,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [swing_ar_pkg::ACT_W-1:0]      action,
    output logic [swing_ar_pkg::RANK_W-1:0]     peer,
    output logic [swing_ar_pkg::STEP_W-1:0]     step_index,
    output logic                                last_of_run
);

    swing_ar_pkg::dp_cmd_t    cmd;
    swing_ar_pkg::dp_status_t status;

    swing_ar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    swing_ar_datapath #(
        .MAX_STEPS (MAX_STEPS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .member_rank (member_rank),
        .group_size  (group_size),
        .cmd         (cmd),
        .status      (status),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .action      (action),
        .peer        (peer),
        .step_index  (step_index),
        .last_of_run (last_of_run)
    );

endmodule
